FILE: sv/skti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared widths, defaults, operation codes, sequencer states and the cell command type.
// ----------------------------------------------------------------------------
package skti_pkg;

  localparam int KIND_BITS      = 3;
  localparam int ID_FIELD_BITS  = 8;
  localparam int LEVEL_BITS     = 4;
  localparam int COUNT_BITS     = 6;
  localparam int DEFAULT_DEPTH  = 32;
  localparam int DEFAULT_ID_BITS = 8;
  localparam int GROUP_SIZE     = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } skti_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_DONE
  } skti_state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic qry;
  } skti_cmd_t;

endpackage : skti_pkg
`default_nettype wire

FILE: sv/skti_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table channels
// Valid/ready interfaces for request items and result items.
// ----------------------------------------------------------------------------
interface skti_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [2:0] skill_kind;
  logic [7:0] skill_id;
  logic [3:0] skill_level;

  modport source (output valid, op, skill_kind, skill_id, skill_level, input ready);
  modport sink   (input valid, op, skill_kind, skill_id, skill_level, output ready);
endinterface : skti_req_if

interface skti_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic       table_full;
  logic [5:0] entry_count;

  modport source (output valid, hit, table_full, entry_count, input ready);
  modport sink   (input valid, hit, table_full, entry_count, output ready);
endinterface : skti_rsp_if
`default_nettype wire

FILE: sv/skti_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry; keeps it, takes the new entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module skti_cell
  import skti_pkg::*;
#(
  parameter int ENTRY_W = KIND_BITS + DEFAULT_ID_BITS + LEVEL_BITS
) (
  input  wire logic               clk,
  input  wire skti_cmd_t          cmd,
  input  wire logic [ENTRY_W-1:0] new_entry,
  input  wire logic               occ,
  input  wire logic               prev_lt,
  input  wire logic [ENTRY_W-1:0] prev_entry,
  output logic [ENTRY_W-1:0]      entry,
  output logic                    lt,
  output logic                    match
);

  logic [ENTRY_W-1:0] entry_q;
  logic               match_q;

  // The key is the entry without its level bits.
  assign lt    = occ && (entry_q[ENTRY_W-1:LEVEL_BITS] < new_entry[ENTRY_W-1:LEVEL_BITS]);
  assign entry = entry_q;
  assign match = match_q;

  always_ff @(posedge clk) begin
    if (cmd.ins && !lt) begin
      entry_q <= prev_lt ? new_entry : prev_entry;
    end
    if (cmd.qry) begin
      match_q <= occ && (entry_q == new_entry);
    end
  end

endmodule : skti_cell
`default_nettype wire

FILE: sv/skti_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table match reduction
// Registered group OR of the cell match bits, then a final OR of the groups.
// ----------------------------------------------------------------------------
module skti_reduce
  import skti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic [TABLE_DEPTH-1:0] match,
  output logic                        any_hit
);

  localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NUM_GROUPS*GROUP_SIZE-1:0] padded;
  logic [NUM_GROUPS-1:0]            grp_q;

  assign padded = (NUM_GROUPS*GROUP_SIZE)'(match);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        grp_q[g] <= |padded[g*GROUP_SIZE +: GROUP_SIZE];
      end
    end
  end

  assign any_hit = |grp_q;

endmodule : skti_reduce
`default_nettype wire

FILE: sv/sorted_key_table_insert_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table with insert and lookup
// Chain of entry cells kept in key order, with a registered match reduction.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH entries of {kind, id, level}, kept sorted
// by kind and then id, both ascending. Each request item is either an insert
// or a query, and each yields exactly one result item. An insert lands ahead
// of any entry with the same kind and id; when the table is full the insert
// is dropped and the result shows table_full. A query hits when some stored
// entry matches kind, id and level. Only the low ID_BITS bits of the id are
// kept. The cells shift or compare at the accept edge, the match bits are
// then ORed in registered groups of sixteen, and the result register loads
// after that, once the result side can take it. A new item is accepted as
// soon as the previous one has reached the result register, even if that
// result has not been taken yet. No clearing pass is needed after reset: the
// entry count alone marks which cells hold data.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup
  import skti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH,
  parameter int ID_BITS     = DEFAULT_ID_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst,
  skti_req_if.sink    req,
  skti_rsp_if.source  rsp
);

  localparam int ENTRY_W = KIND_BITS + ID_BITS + LEVEL_BITS;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

  skti_state_t state, state_next;

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   req_fire;
  logic                   rsp_fire;
  logic                   full;
  logic                   is_query;
  logic                   grp_load;
  logic                   rsp_load;
  logic                   op_q;
  logic                   drop_q;
  logic                   any_hit;
  logic [ID_BITS-1:0]     id_key;
  logic [ENTRY_W-1:0]     new_entry;
  logic [CNT_W+5:0]       count_ext;
  skti_cmd_t              cmd;

  logic [TABLE_DEPTH-1:0] occ;
  logic [TABLE_DEPTH-1:0] lt;
  logic [TABLE_DEPTH-1:0] match;
  logic [ENTRY_W-1:0]     cell_entry [TABLE_DEPTH];

  // The id port is fixed at eight bits; keep its low ID_BITS bits.
  generate
    if (ID_BITS <= ID_FIELD_BITS) begin : g_id_narrow
      assign id_key = req.skill_id[ID_BITS-1:0];
    end else begin : g_id_wide
      assign id_key = ID_BITS'(req.skill_id);
    end
  endgenerate

  assign new_entry = {req.skill_kind, id_key, req.skill_level};

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign is_query = (req.op == OP_QUERY);

  // Cells only act on the edge at which an item is accepted. A dropped
  // insert leaves every cell untouched.
  assign cmd.ins = req_fire && !is_query && !full;
  assign cmd.qry = req_fire && is_query;

  // The entry count is the table's only notion of which cells are filled.
  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        // The head cell has no neighbor, so a non-less key always takes the
        // new entry there.
        skti_cell #(.ENTRY_W(ENTRY_W)) u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .new_entry  (new_entry),
          .occ        (occ[i]),
          .prev_lt    (1'b1),
          .prev_entry ('0),
          .entry      (cell_entry[i]),
          .lt         (lt[i]),
          .match      (match[i])
        );
      end else begin : g_body
        skti_cell #(.ENTRY_W(ENTRY_W)) u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .new_entry  (new_entry),
          .occ        (occ[i]),
          .prev_lt    (lt[i-1]),
          .prev_entry (cell_entry[i-1]),
          .entry      (cell_entry[i]),
          .lt         (lt[i]),
          .match      (match[i])
        );
      end
    end
  endgenerate

  skti_reduce #(.TABLE_DEPTH(TABLE_DEPTH)) u_reduce (
    .clk     (clk),
    .load    (grp_load),
    .match   (match),
    .any_hit (any_hit)
  );

  // Count update happens together with the cell shift.
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Per-item context that the result needs.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q   <= req.op;
      drop_q <= !is_query && full;
    end
  end

  // Sequencer: accept, group reduction, result load.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_GROUP;
        end
      end
      ST_GROUP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    grp_load  = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_GROUP: begin
        grp_load = 1'b1;
      end
      ST_DONE: begin
        rsp_load = !rsp.valid || rsp.ready;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register. It holds a finished result while the block is free to
  // take the next request item.
  assign count_ext = (CNT_W+6)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp_fire) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.hit         <= (op_q == OP_QUERY) ? any_hit : !drop_q;
      rsp.table_full  <= (op_q == OP_INSERT) && drop_q;
      rsp.entry_count <= count_ext[5:0];
    end
  end

  // The count never passes the table depth.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // A stored insert grows the table by exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.op == OP_INSERT && !full)
      |=> (count == $past(count) + CNT_W'(1)))
    else $error("stored insert did not advance the count");

  // A dropped insert or a query leaves the count alone.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.op == OP_QUERY || full))
      |=> (count == $past(count)))
    else $error("count changed on a query or a dropped insert");

  // Every accepted item is handed to the group reduction state, and nothing
  // new is accepted in that state.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_GROUP && !req.ready))
    else $error("item not handed to the reduction stage");

  // A result flagged as full never claims a stored entry.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.table_full))
    else $error("result shows both hit and table full");

endmodule : sorted_key_table_insert_lookup
`default_nettype wire
